>>> rtl/segment_time_allocation_unit_macros.svh
// Assertion helpers for the segment time allocation unit.
`ifndef SEGMENT_TIME_ALLOCATION_UNIT_MACROS_SVH
`define SEGMENT_TIME_ALLOCATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define STAU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment time allocation: check failed");

// Next-cycle implication.
`define STAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment time allocation: check failed");

`endif

>>> rtl/stau_pkg.sv
package stau_pkg;

   localparam int SPEED_W   = 24;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_W     = ((TIME_W + SPEED_W + 1 + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCEL     = 2'd2;

   localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(1) << 16;
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

   typedef struct packed {
      logic start;
      logic accumulate;
   } mul_ctl_type;

endpackage

>>> rtl/segment_time_allocation_unit.sv
// Segment time allocation under a trapezoidal speed profile.
// req_ channel: one 3D path point per item; req_tuser marks the first point
// of a path, which is stored with the speed loaded from initial_speed and
// gives no result. Every later point gives one rsp_ item: the segment time,
// the speed at the segment end and a saturation flag.
// csr_ channel: register writes (initial speed, max speed, max accel); write
// only while no item is in flight.
// A path start is stored in the idle state. Other points run through one
// shared shift-add multiplier, one root unit and one divider, one operation
// at a time. Whether the segment reaches cruise or stays acceleration
// limited, req_tready is low from acceptance until the result is loaded, so
// a new point is taken only once the last one is through. Results sit in an
// output register; a new point is taken while a result waits, and a
// finished result holds the sequencer until rsp_tready frees the register.
// Reset clears the path state and loads the register defaults
// (initial speed 0, max speed and max accel 1.0).
`include "segment_time_allocation_unit_macros.svh"

module segment_time_allocation_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int REQ_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_W-1:0]               req_tdata,  // pos_x, pos_y, pos_z, zero pad
   input  logic                           req_tuser,  // start_of_path
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [stau_pkg::RSP_W-1:0]     rsp_tdata,  // segment_time, speed_reached,
                                                      // time_saturated, zero pad
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [stau_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [stau_pkg::SPEED_W-1:0]   csr_data
);

   localparam int SW   = stau_pkg::SPEED_W;
   localparam int TW   = stau_pkg::TIME_W;
   localparam int DW   = COORD_WIDTH + 1;
   localparam int PW0  = 2 * DW + 2;
   localparam int PW   = (PW0 > 64) ? PW0 : 64;
   localparam int HW   = PW / 2;
   localparam int MW   = (DW > 32) ? DW : 32;
   localparam int NW0  = HW + FRAC_BITS;
   localparam int NUMW = (NW0 > 2 * SW) ? NW0 : 2 * SW;
   localparam int DENW = SW + 1;
   localparam int PADW = stau_pkg::RSP_W - TW - SW - 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_ROOT_D, ST_VMAX2, ST_V2, ST_DACC,
      ST_T1, ST_T2, ST_PROD, ST_ROOT_S, ST_TQ, ST_SPEED, ST_OUT
   } state_type;

   state_type state_ff;
   logic      issued_ff;

   logic [SW-1:0] init_speed_ff;
   logic [SW-1:0] max_speed_ff;
   logic [SW-1:0] max_accel_ff;

   logic [COORD_WIDTH-1:0] prev_x_ff;
   logic [COORD_WIDTH-1:0] prev_y_ff;
   logic [COORD_WIDTH-1:0] prev_z_ff;
   logic [SW-1:0]          run_speed_ff;
   logic                   have_prev_ff;

   logic [DW-1:0]   ax_ff, ay_ff, az_ff;
   logic [SW-1:0]   vm_ff, ac_ff, v_ff;
   logic [HW-1:0]   d_ff;
   logic [2*SW-1:0] vm2_ff, v2_ff;
   logic [NUMW-1:0] dacc_ff;
   logic [TW-1:0]   t1_ff, t_ff;
   logic            sat_ff;
   logic [SW-1:0]   spd_ff;

   logic          rsp_valid_ff;
   logic [TW-1:0] rsp_time_ff;
   logic [SW-1:0] rsp_speed_ff;
   logic          rsp_sat_ff;

   logic signed [COORD_WIDTH-1:0] x, y, z;
   logic signed [DW-1:0] dx, dy, dz;
   logic [SW-1:0] vm_eff, ac_eff;

   stau_pkg::mul_ctl_type mul_ctl;
   logic [PW-1:0]   mul_a, mul_prod;
   logic [MW-1:0]   mul_b;
   logic            mul_busy;
   logic            sqrt_start, sqrt_busy;
   logic [PW-1:0]   sqrt_rad;
   logic [HW-1:0]   sqrt_root;
   logic            div_start, div_busy;
   logic [NUMW-1:0] div_num, div_quot;
   logic [DENW-1:0] div_den;
   logic            unit_busy;

   logic [TW-1:0]   q_time;
   logic            q_sat;
   logic [TW:0]     t_sum;
   logic [PW-1:0]   spd_sum;
   logic            req_fire;
   logic            rsp_load;

   assign x = req_tdata[COORD_WIDTH-1:0];
   assign y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign z = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

   assign dx = DW'(x) - DW'($signed(prev_x_ff));
   assign dy = DW'(y) - DW'($signed(prev_y_ff));
   assign dz = DW'(z) - DW'($signed(prev_z_ff));

   assign vm_eff = (max_speed_ff != '0) ? max_speed_ff : SW'(1);
   assign ac_eff = (max_accel_ff != '0) ? max_accel_ff : SW'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   assign q_sat  = |div_quot[NUMW-1:TW];
   assign q_time = q_sat ? stau_pkg::TIME_MAX : div_quot[TW-1:0];
   assign t_sum  = {1'b0, t1_ff} + {1'b0, q_time};
   assign spd_sum = PW'(v_ff) + (mul_prod >> FRAC_BITS);

   // operand selection for the shared units
   always_comb begin
      mul_ctl    = '0;
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = 1'b0;
      sqrt_rad   = '0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      unit_busy  = 1'b0;
      unique case (state_ff)
         ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_VMAX2, ST_V2, ST_PROD, ST_SPEED: begin
            mul_ctl.start      = !issued_ff;
            mul_ctl.accumulate = (state_ff == ST_SQ_Y) || (state_ff == ST_SQ_Z);
            unit_busy          = mul_busy;
            case (state_ff)
               ST_SQ_X: begin
                  mul_a = PW'(ax_ff);
                  mul_b = MW'(ax_ff);
               end
               ST_SQ_Y: begin
                  mul_a = PW'(ay_ff);
                  mul_b = MW'(ay_ff);
               end
               ST_SQ_Z: begin
                  mul_a = PW'(az_ff);
                  mul_b = MW'(az_ff);
               end
               ST_VMAX2: begin
                  mul_a = PW'(vm_ff);
                  mul_b = MW'(vm_ff);
               end
               ST_V2: begin
                  mul_a = PW'(v_ff);
                  mul_b = MW'(v_ff);
               end
               ST_PROD: begin
                  mul_a = PW'(d_ff);
                  mul_b = MW'({ac_ff, 1'b0});
               end
               default: begin
                  mul_a = PW'(ac_ff);
                  mul_b = MW'(t_ff);
               end
            endcase
         end
         ST_ROOT_D, ST_ROOT_S: begin
            sqrt_start = !issued_ff;
            unit_busy  = sqrt_busy;
            sqrt_rad   = (state_ff == ST_ROOT_D) ? mul_prod : (PW'(v2_ff) + mul_prod);
         end
         ST_DACC, ST_T1, ST_T2, ST_TQ: begin
            div_start = !issued_ff;
            unit_busy = div_busy;
            case (state_ff)
               ST_DACC: begin
                  div_num = NUMW'(vm2_ff - v2_ff);
                  div_den = {ac_ff, 1'b0};
               end
               ST_T1: begin
                  div_num = NUMW'(vm_ff - v_ff) << FRAC_BITS;
                  div_den = DENW'(ac_ff);
               end
               ST_T2: begin
                  div_num = NUMW'(d_ff - dacc_ff[HW-1:0]) << FRAC_BITS;
                  div_den = DENW'(vm_ff);
               end
               default: begin
                  div_num = NUMW'(d_ff - HW'(v_ff)) << FRAC_BITS;
                  div_den = DENW'(ac_ff);
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   stau_mul #(.AW(PW), .BW(MW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .a       (mul_a),
      .b       (mul_b),
      .busy    (mul_busy),
      .product (mul_prod)
   );

   stau_sqrt #(.W(PW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   stau_div #(.NW(NUMW), .DW(DENW)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .busy        (div_busy),
      .quotient    (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issued_ff     <= 1'b0;
         init_speed_ff <= '0;
         max_speed_ff  <= SW'(1) << FRAC_BITS;
         max_accel_ff  <= SW'(1) << FRAC_BITS;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
         run_speed_ff  <= '0;
         have_prev_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               stau_pkg::CSR_INITIAL_SPEED: init_speed_ff <= csr_data;
               stau_pkg::CSR_MAX_SPEED:     max_speed_ff  <= csr_data;
               stau_pkg::CSR_MAX_ACCEL:     max_accel_ff  <= csr_data;
               default: begin
               end
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_time_ff  <= t_ff;
            rsp_speed_ff <= spd_ff;
            rsp_sat_ff   <= sat_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (state_ff != ST_IDLE && state_ff != ST_OUT) begin
            if (!issued_ff) begin
               issued_ff <= 1'b1;
            end else if (!unit_busy) begin
               issued_ff <= 1'b0;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  prev_x_ff <= x;
                  prev_y_ff <= y;
                  prev_z_ff <= z;
                  if (req_tuser || !have_prev_ff) begin
                     run_speed_ff <= init_speed_ff;
                     have_prev_ff <= 1'b1;
                  end else begin
                     ax_ff    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
                     ay_ff    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
                     az_ff    <= dz[DW-1] ? DW'(-dz) : DW'(dz);
                     vm_ff    <= vm_eff;
                     ac_ff    <= ac_eff;
                     v_ff     <= (run_speed_ff < vm_eff) ? run_speed_ff : vm_eff;
                     sat_ff   <= 1'b0;
                     state_ff <= ST_SQ_X;
                  end
               end
            end
            ST_SQ_X: if (issued_ff && !unit_busy) state_ff <= ST_SQ_Y;
            ST_SQ_Y: if (issued_ff && !unit_busy) state_ff <= ST_SQ_Z;
            ST_SQ_Z: if (issued_ff && !unit_busy) state_ff <= ST_ROOT_D;
            ST_ROOT_D: begin
               if (issued_ff && !unit_busy) begin
                  d_ff     <= sqrt_root;
                  state_ff <= ST_VMAX2;
               end
            end
            ST_VMAX2: begin
               if (issued_ff && !unit_busy) begin
                  vm2_ff   <= mul_prod[2*SW-1:0];
                  state_ff <= ST_V2;
               end
            end
            ST_V2: begin
               if (issued_ff && !unit_busy) begin
                  v2_ff    <= mul_prod[2*SW-1:0];
                  state_ff <= ST_DACC;
               end
            end
            ST_DACC: begin
               if (issued_ff && !unit_busy) begin
                  dacc_ff  <= div_quot;
                  state_ff <= (NUMW'(d_ff) > div_quot) ? ST_T1 : ST_PROD;
               end
            end
            ST_T1: begin
               if (issued_ff && !unit_busy) begin
                  t1_ff    <= q_time;
                  sat_ff   <= q_sat;
                  state_ff <= ST_T2;
               end
            end
            ST_T2: begin
               if (issued_ff && !unit_busy) begin
                  t_ff     <= t_sum[TW] ? stau_pkg::TIME_MAX : t_sum[TW-1:0];
                  sat_ff   <= sat_ff || q_sat || t_sum[TW];
                  spd_ff   <= vm_ff;
                  state_ff <= ST_OUT;
               end
            end
            ST_PROD: if (issued_ff && !unit_busy) state_ff <= ST_ROOT_S;
            ST_ROOT_S: begin
               if (issued_ff && !unit_busy) begin
                  d_ff     <= (sqrt_root < HW'(v_ff)) ? HW'(v_ff) : sqrt_root;
                  state_ff <= ST_TQ;
               end
            end
            ST_TQ: begin
               if (issued_ff && !unit_busy) begin
                  t_ff     <= q_time;
                  sat_ff   <= q_sat;
                  state_ff <= ST_SPEED;
               end
            end
            ST_SPEED: begin
               if (issued_ff && !unit_busy) begin
                  spd_ff   <= (spd_sum > PW'(vm_ff)) ? vm_ff : spd_sum[SW-1:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_load) begin
                  run_speed_ff <= spd_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PADW'(0), rsp_sat_ff, rsp_speed_ff, rsp_time_ff};

   `STAU_ASSERT_IMPLIES(a_speed_within_limit, clock, reset, rsp_load, spd_ff <= vm_ff)
   `STAU_ASSERT_IMPLIES(a_div_start_idle, clock, reset, div_start, !div_busy)
   `STAU_ASSERT_IMPLIES(a_mul_start_idle, clock, reset, mul_ctl.start, !mul_busy)
   `STAU_ASSERT_IMPLIES(a_path_kept, clock, reset, 1'b1, !$fell(have_prev_ff))

endmodule

>>> rtl/stau_mul.sv
module stau_mul #(
   parameter int AW = 64,
   parameter int BW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stau_pkg::mul_ctl_type ctl,
   input  logic [AW-1:0]        a,
   input  logic [BW-1:0]        b,
   output logic                 busy,
   output logic [AW-1:0]        product
);

   localparam int CW = $clog2(BW + 1);

   logic [AW-1:0] mcand_ff;
   logic [BW-1:0] mplier_ff;
   logic [AW-1:0] acc_ff;
   logic [CW-1:0] cnt_ff;

   // shift-add, one multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.start) begin
         mcand_ff  <= a;
         mplier_ff <= b;
         if (!ctl.accumulate) begin
            acc_ff <= '0;
         end
         cnt_ff <= CW'(BW);
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         cnt_ff    <= cnt_ff - 1'b1;
      end
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

endmodule

>>> rtl/stau_sqrt.sv
module stau_sqrt #(
   parameter int W = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   radicand,
   output logic           busy,
   output logic [W/2-1:0] root
);

   localparam int HW  = W / 2;
   localparam int RMW = HW + 3;
   localparam int CW  = $clog2(HW + 1);

   logic [W-1:0]   rad_ff;
   logic [RMW-1:0] rem_ff;
   logic [HW-1:0]  root_ff;
   logic [CW-1:0]  cnt_ff;
   logic [RMW-1:0] rem_cat;
   logic [RMW-1:0] trial;

   assign rem_cat = {rem_ff[RMW-3:0], rad_ff[W-1:W-2]};
   assign trial   = RMW'({root_ff, 2'b01});

   // restoring root, two radicand bits per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CW'(HW);
      end else if (cnt_ff != '0) begin
         rad_ff <= rad_ff << 2;
         if (rem_cat >= trial) begin
            rem_ff  <= rem_cat - trial;
            root_ff <= {root_ff[HW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_cat;
            root_ff <= {root_ff[HW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule

>>> rtl/stau_div.sv
module stau_div #(
   parameter int NW = 50,
   parameter int DW = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numerator,
   input  logic [DW-1:0] denominator,
   output logic          busy,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [NW-1:0] q_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW:0]   rem_cat;
   logic [DW:0]   diff;

   assign rem_cat = {rem_ff, q_ff[NW-1]};
   assign diff    = rem_cat - {1'b0, den_ff};

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         den_ff <= denominator;
         rem_ff <= '0;
         q_ff   <= numerator;
         cnt_ff <= CW'(NW);
      end else if (cnt_ff != '0) begin
         if (rem_cat >= {1'b0, den_ff}) begin
            rem_ff <= diff[DW-1:0];
            q_ff   <= {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_cat[DW-1:0];
            q_ff   <= {q_ff[NW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = q_ff;

endmodule
